>>> design/lifna_pkg.sv
// shared types and constants for the leaky integrate-and-fire neuron array
package lifna_pkg;

    localparam int POT_W   = 16;
    localparam int GAIN_W  = 16;
    localparam int IDX_W   = 10;
    localparam int CNT_W   = 32;
    localparam int CFG_IDX_W = 3;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_REST_POTENTIAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_POTENTIAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRE_THRESHOLD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEAK_GAIN       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN      = 3'd4;

    // reset values, Q8.8 mV and Q0.16
    localparam logic signed [POT_W-1:0] REST_DEFAULT      = -16'sd16640;
    localparam logic signed [POT_W-1:0] RESET_DEFAULT     = -16'sd16640;
    localparam logic signed [POT_W-1:0] THRESHOLD_DEFAULT = 16'sd5120;
    localparam logic [GAIN_W-1:0]       LEAK_DEFAULT      = 16'd328;
    localparam logic [GAIN_W-1:0]       INPUT_DEFAULT     = 16'd3277;

    typedef struct packed {
        logic signed [POT_W-1:0] rest_potential;
        logic signed [POT_W-1:0] reset_potential;
        logic signed [POT_W-1:0] fire_threshold;
        logic [GAIN_W-1:0]       leak_gain;
        logic [GAIN_W-1:0]       input_gain;
    } cfg_t;

endpackage

>>> design/lifna_euler.sv
// two-stage euler step: gain products, then rounded sum and saturating add
module lifna_euler (
    input  logic                                  aclk,
    input  logic                                  en_mul,
    input  logic                                  en_sum,
    input  lifna_pkg::cfg_t                       cfg,
    input  logic signed [lifna_pkg::POT_W-1:0]    v_in,
    input  logic signed [lifna_pkg::POT_W-1:0]    current,
    output logic signed [lifna_pkg::POT_W-1:0]    v_out
);
    import lifna_pkg::*;

    logic signed [POT_W:0]     diff;
    logic signed [GAIN_W:0]    gain_in;
    logic signed [GAIN_W:0]    gain_leak;
    logic signed [32:0]        prod_in_next;
    logic signed [33:0]        prod_leak_next;
    logic signed [32:0]        prod_in_reg;
    logic signed [33:0]        prod_leak_reg;
    logic signed [POT_W-1:0]   v_d1_reg;
    logic signed [34:0]        sum_full;
    logic signed [18:0]        step_reg;
    logic signed [POT_W-1:0]   v_d2_reg;
    logic signed [19:0]        v_wide;

    // leak uses the potential relative to rest, 17 bits wide
    assign diff      = $signed({v_in[POT_W-1], v_in})
                     - $signed({cfg.rest_potential[POT_W-1], cfg.rest_potential});
    assign gain_in   = $signed({1'b0, cfg.input_gain});
    assign gain_leak = $signed({1'b0, cfg.leak_gain});

    assign prod_in_next   = gain_in * current;
    assign prod_leak_next = gain_leak * diff;

    always_ff @(posedge aclk) begin
        if (en_mul) begin
            prod_in_reg   <= prod_in_next;
            prod_leak_reg <= prod_leak_next;
            v_d1_reg      <= v_in;
        end
    end

    // round to nearest, ties up: add half an lsb, drop 16 bits (floor)
    assign sum_full = 35'(prod_in_reg) - 35'(prod_leak_reg) + 35'sd32768;

    always_ff @(posedge aclk) begin
        if (en_sum) begin
            step_reg <= sum_full[34:16];
            v_d2_reg <= v_d1_reg;
        end
    end

    assign v_wide = 20'(v_d2_reg) + 20'(step_reg);

    always_comb begin
        if (v_wide > 20'sd32767) begin
            v_out = 16'sh7FFF;
        end else if (v_wide < -20'sd32768) begin
            v_out = 16'sh8000;
        end else begin
            v_out = v_wide[POT_W-1:0];
        end
    end

endmodule

>>> design/lif_neuron_array_update.sv
// top level of the leaky integrate-and-fire neuron array update block
//
// Each input item names a neuron and the current injected into it for one
// time step. The block reads the neuron's membrane potential from an on-chip
// memory, adds input_gain*current - leak_gain*(v - rest) scaled by 2^-16 and
// rounded, saturates to 16 bits, and fires when the result reaches the
// threshold (the potential is then replaced by reset_potential and the
// saturating spike count goes up). One result item comes back per input item.
// An item passes through accept with memory read, multiply, rounded sum and
// write back; the single memory port pair and the write back before the next
// read mean that a new item is accepted only once the last is written back,
// so no forwarding is needed. A result waiting in the output register does
// not stop the next item from being accepted. After reset the block runs a
// clearing pass that writes REST_DEFAULT into every memory entry, one per
// cycle, with s_tready low; configuration writes are taken meanwhile.
// Items whose index is not below NEURON_COUNT leave all state alone and
// return spiked 0, new_potential 0 and the current spike count.
module lif_neuron_array_update #(
    parameter int NEURON_COUNT = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [lifna_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [15:0]                        cfg_wdata,
    // input items
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [31:0]                        s_tdata,   // neuron_index, input_current
    // result items
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [63:0]                        m_tdata    // out_neuron_index, spiked,
                                                          // new_potential, spike_total
);
    import lifna_pkg::*;

    // only indexes reachable through the 10 bit field need storage
    localparam int MEM_DEPTH = (NEURON_COUNT < (1 << IDX_W)) ? NEURON_COUNT : (1 << IDX_W);
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam logic [16:0]   COUNT_LIMIT = 17'(NEURON_COUNT);
    localparam logic [AW-1:0] LAST_ADDR   = AW'(MEM_DEPTH - 1);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_MUL   = 5'b00100,
        ST_SUM   = 5'b01000,
        ST_WB    = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    cfg_t                     cfg_reg;
    logic [AW-1:0]            clr_addr_reg;

    // item held while it is worked on
    logic [IDX_W-1:0]         idx_reg;
    logic signed [POT_W-1:0]  cur_reg;
    logic                     in_range_reg;

    // membrane memory
    logic signed [POT_W-1:0]  mem [MEM_DEPTH];
    logic signed [POT_W-1:0]  rd_data_reg;
    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic signed [POT_W-1:0]  mem_wdata;

    // datapath
    logic signed [POT_W-1:0]  v_sat;
    logic                     fire;
    logic signed [POT_W-1:0]  v_final;
    logic                     s_accept;
    logic                     out_free;
    logic                     wb_go;

    logic [CNT_W-1:0]         spike_cnt_reg;

    // output register
    logic                     m_valid_reg;
    logic [IDX_W-1:0]         o_idx_reg;
    logic                     o_spiked_reg;
    logic signed [POT_W-1:0]  o_pot_reg;
    logic [CNT_W-1:0]         o_total_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign wb_go    = (state_reg == ST_WB) && out_free;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rest_potential  <= REST_DEFAULT;
            cfg_reg.reset_potential <= RESET_DEFAULT;
            cfg_reg.fire_threshold  <= THRESHOLD_DEFAULT;
            cfg_reg.leak_gain       <= LEAK_DEFAULT;
            cfg_reg.input_gain      <= INPUT_DEFAULT;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_REST_POTENTIAL:  cfg_reg.rest_potential  <= cfg_wdata;
                REG_RESET_POTENTIAL: cfg_reg.reset_potential <= cfg_wdata;
                REG_FIRE_THRESHOLD:  cfg_reg.fire_threshold  <= cfg_wdata;
                REG_LEAK_GAIN:       cfg_reg.leak_gain       <= cfg_wdata;
                REG_INPUT_GAIN:      cfg_reg.input_gain      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == LAST_ADDR) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_accept) state_next = ST_MUL;
            end
            ST_MUL:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_WB;
            ST_WB: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    // capture the item; the memory read is issued in the same cycle
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            idx_reg      <= s_tdata[IDX_W-1:0];
            cur_reg      <= s_tdata[IDX_W+POT_W-1:IDX_W];
            in_range_reg <= (17'(s_tdata[IDX_W-1:0]) < COUNT_LIMIT);
        end
    end

    // one write port shared by the clearing pass and write back
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = REST_DEFAULT;
        end else begin
            mem_we    = wb_go && in_range_reg;
            mem_waddr = idx_reg[AW-1:0];
            mem_wdata = v_final;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (s_accept) rd_data_reg <= mem[s_tdata[AW-1:0]];
    end

    lifna_euler u_euler (
        .aclk    (aclk),
        .en_mul  (state_reg == ST_MUL),
        .en_sum  (state_reg == ST_SUM),
        .cfg     (cfg_reg),
        .v_in    (rd_data_reg),
        .current (cur_reg),
        .v_out   (v_sat)
    );

    // threshold test on the saturated potential
    assign fire    = in_range_reg && (v_sat >= cfg_reg.fire_threshold);
    assign v_final = fire ? cfg_reg.reset_potential : v_sat;

    // saturating spike count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spike_cnt_reg <= '0;
        end else if (wb_go && fire && (spike_cnt_reg != '1)) begin
            spike_cnt_reg <= spike_cnt_reg + CNT_W'(1);
        end
    end

    // output register, loaded on write back, drained by m_tready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (wb_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wb_go) begin
            o_idx_reg    <= idx_reg;
            o_spiked_reg <= fire;
            o_pot_reg    <= in_range_reg ? v_final : '0;
            o_total_reg  <= (fire && (spike_cnt_reg != '1)) ? spike_cnt_reg + CNT_W'(1)
                                                            : spike_cnt_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, o_total_reg, o_pot_reg, o_spiked_reg, o_idx_reg};

endmodule
